@@ hdl/nlg_pkg.sv @@
// nlg_pkg: shared types and widths for the normal line generator
// no dependencies; imported by nlg_mul, nlg_div, nlg_sqrt and normal_line_generator_top
`default_nettype none
package nlg_pkg;

  // signed q16.16 coordinate
  typedef logic signed [31:0] q16_t;

  // shared multiplier operand width and product width
  localparam int unsigned MulW  = 32;
  localparam int unsigned ProdW = 2 * MulW;

  // iterative divider widths
  localparam int unsigned DivNumW = 48;
  localparam int unsigned DivDenW = 34;

  // square root radicand width and root width
  localparam int unsigned SqrtInW  = 64;
  localparam int unsigned SqrtOutW = SqrtInW / 2;

  // configuration register indexes
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_VNORM = 1'b1;

endpackage
`default_nettype wire

@@ hdl/nlg_mul.sv @@
// nlg_mul: shared unsigned multiplier with a registered product and sign tag
// depends on nlg_pkg
`default_nettype none
module nlg_mul import nlg_pkg::*; (
  input  logic             clk_i,
  input  logic [MulW-1:0]  a_i,
  input  logic [MulW-1:0]  b_i,
  input  logic             neg_i,
  output logic [ProdW-1:0] p_o,
  output logic             neg_o
);

  logic [ProdW-1:0] p_q;
  logic             neg_q;

  // one product per cycle, sign travels alongside
  always_ff @(posedge clk_i) begin
    p_q   <= a_i * b_i;
    neg_q <= neg_i;
  end

  assign p_o   = p_q;
  assign neg_o = neg_q;

endmodule
`default_nettype wire

@@ hdl/nlg_div.sv @@
// nlg_div: restoring divider, one quotient bit per cycle
// depends on nlg_pkg
`default_nettype none
module nlg_div import nlg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic [DivNumW-1:0] quo_o,
  output logic               done_o
);

  localparam int unsigned CntW = $clog2(DivNumW);

  logic [DivNumW-1:0] num_q, quo_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   rem2;
  logic               fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem2 = {rem_q[DivDenW-1:0], num_q[DivNumW-1]};
    fits = (rem2 >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        num_q  <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= fits ? (rem2 - {1'b0, den_q}) : rem2;
        quo_q <= {quo_q[DivNumW-2:0], fits};
        num_q <= {num_q[DivNumW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ hdl/nlg_sqrt.sv @@
// nlg_sqrt: integer square root, one root bit per cycle
// depends on nlg_pkg
`default_nettype none
module nlg_sqrt import nlg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [SqrtInW-1:0]  rad_i,
  output logic [SqrtOutW-1:0] root_o,
  output logic                done_o
);

  localparam int unsigned CntW = $clog2(SqrtOutW);
  localparam int unsigned RemW = SqrtOutW + 3;

  logic [SqrtInW-1:0]  x_q;
  logic [SqrtOutW-1:0] root_q;
  logic [RemW-1:0]     rem_q;
  logic [CntW-1:0]     cnt_q;
  logic                busy_q, done_q;
  logic [RemW-1:0]     rem2, trial;
  logic                fits;

  // bring down two radicand bits and try root*4+1
  always_comb begin
    rem2  = {rem_q[RemW-3:0], x_q[SqrtInW-1 -: 2]};
    trial = {1'b0, root_q, 2'b01};
    fits  = (rem2 >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        x_q    <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rem_q  <= fits ? (rem2 - trial) : rem2;
        root_q <= {root_q[SqrtOutW-2:0], fits};
        x_q    <= {x_q[SqrtInW-3:0], 2'b00};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtOutW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

@@ hdl/normal_line_generator_top.sv @@
// normal_line_generator_top: sequencer around a shared multiplier, divider and root unit
// depends on nlg_pkg, nlg_mul, nlg_div, nlg_sqrt
//
// channel   direction  fields (lowest bit first)
// s_axis    in         tdata: pos_x pos_y pos_z norm_x norm_y norm_z
// m_axis    out        tdata: start_x..z end_x..z first_index; tuser line_kind; tlast last
// cfg       in         index 0 scale_factor, index 1 has_vertex_normals
//
// the first two vertices of a triangle are only stored
// third vertex: edge vectors, cross product through the shared multiplier, the one-bit normalizing
// shift, the root unit and the shared divider (one division per normal component, three
// components) before the first line; a degenerate triangle skips the root unit and divider
// each line: three scaled normal components through the shared multiplier, then it is presented until taken
// s_axis_tready is low while a triangle is processed; reset needs no clearing pass
`default_nettype none
module normal_line_generator_top import nlg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // pos_x pos_y pos_z norm_x norm_y norm_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata,   // start_x start_y start_z end_x end_y end_z first_index
  output logic         m_axis_tuser,   // line_kind
  output logic         m_axis_tlast,   // last_of_triangle
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  // divide by three: 2^32 = 3 * Third2p32 + 1, low word through a reciprocal multiply
  localparam logic [31:0] Recip3    = 32'hAAAA_AAAB;
  localparam logic [31:0] Third2p32 = 32'd1431655765;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE, S_CROSS, S_MAG, S_NORM, S_SQ, S_ROOT, S_DIVF, S_CTR, S_LEND, S_OUT
  } state_e;

  state_e             state_q;
  logic [1:0]         phase_q;
  logic [31:0]        lvi_q, scale_q;
  logic               vnorm_q, wait_q;
  logic [2:0]         cnt_q;
  logic [1:0]         line_q, last_line_q;
  q16_t               hpos_q [3][3];
  q16_t               hnrm_q [3][3];
  logic signed [32:0] v_q [3];
  logic signed [32:0] w_q [3];
  logic signed [65:0] cr_q [3];
  logic [64:0]        mag_q [3];
  logic               neg_q [3];
  logic [63:0]        sum_q;
  logic [31:0]        len_q;
  q16_t               fn_q [3];
  q16_t               ctr_q [3];
  q16_t               st_q [3];
  q16_t               end_q [3];
  logic [31:0]        fidx_q;
  logic               kind_q, last_q, mvalid_q;

  function automatic logic [31:0] mag_w(input logic signed [32:0] x);
    logic [32:0] t;
    t = x[32] ? 33'(-x) : 33'(x);
    return t[31:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 32'h0001_0000;
      vnorm_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE: scale_q <= cfg_data_i;
        REG_VNORM: vnorm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // shared units
  logic [MulW-1:0]     mul_a, mul_b;
  logic                mul_neg, mulp_neg;
  logic [ProdW-1:0]    mul_p;
  logic                div_start, div_done, rt_start, rt_done;
  logic [DivNumW-1:0]  div_num, div_quo;
  logic [DivDenW-1:0]  div_den;
  logic [SqrtOutW-1:0] rt_root;

  nlg_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .neg_i(mul_neg), .p_o(mul_p),
                 .neg_o(mulp_neg));
  nlg_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
                 .quo_o(div_quo), .done_o(div_done));
  nlg_sqrt u_sqrt (.clk_i, .rst_ni, .start_i(rt_start), .rad_i(sum_q), .root_o(rt_root),
                   .done_o(rt_done));

  // operand selection and derived values
  logic signed [32:0] op_a, op_b;
  logic [1:0]         iss, con, sel;
  q16_t               cur_st [3];
  q16_t               cur_n [3];
  logic signed [33:0] csum [3];
  logic [32:0]        cmag [3];
  logic [32:0]        cx [3];
  logic [31:0]        cy [3];
  logic [31:0]        cq;
  logic signed [65:0] term;
  logic [64:0]        orv, rnd;
  logic [48:0]        rsh;
  logic signed [50:0] ext, eres;
  q16_t               esat;
  logic [2:0]         cm1;

  always_comb begin
    iss = (cnt_q[1:0] == 2'd3) ? 2'd0 : cnt_q[1:0];
    cm1 = cnt_q - 3'd1;
    con = (cm1[1:0] == 2'd3) ? 2'd0 : cm1[1:0];
    sel = line_q - 2'd1;
    for (int c = 0; c < 3; c++) begin
      cur_st[c] = (line_q == 2'd0) ? ctr_q[c] : hpos_q[sel][c];
      cur_n[c]  = (line_q == 2'd0) ? fn_q[c]  : hnrm_q[sel][c];
      csum[c]   = 34'(hpos_q[0][c]) + 34'(hpos_q[1][c]) + 34'(hpos_q[2][c]);
      cmag[c]   = csum[c][33] ? 33'(-csum[c]) : 33'(csum[c]);
      // rounded center numerator, high bit folded into the low word
      cx[c]     = cmag[c] + 33'd1;
      cy[c]     = cx[c][31:0] + 32'(cx[c][32]);
    end
    case (cnt_q)
      3'd0:    begin op_a = v_q[1]; op_b = w_q[2]; end
      3'd1:    begin op_a = v_q[2]; op_b = w_q[1]; end
      3'd2:    begin op_a = v_q[2]; op_b = w_q[0]; end
      3'd3:    begin op_a = v_q[0]; op_b = w_q[2]; end
      3'd4:    begin op_a = v_q[0]; op_b = w_q[1]; end
      default: begin op_a = v_q[1]; op_b = w_q[0]; end
    endcase
    case (state_q)
      S_CROSS: begin
        mul_a = mag_w(op_a); mul_b = mag_w(op_b); mul_neg = op_a[32] ^ op_b[32];
      end
      S_SQ: begin
        mul_a = mag_q[iss][31:0]; mul_b = mag_q[iss][31:0]; mul_neg = 1'b0;
      end
      S_CTR: begin
        mul_a = cy[iss]; mul_b = Recip3; mul_neg = 1'b0;
      end
      S_LEND: begin
        mul_a = mag_w(33'(cur_n[iss])); mul_b = scale_q; mul_neg = cur_n[iss][31];
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_neg = 1'b0;
      end
    endcase
    // cross product term with its sign
    term = mulp_neg ? -$signed({2'b00, mul_p}) : $signed({2'b00, mul_p});
    orv  = mag_q[0] | mag_q[1] | mag_q[2];
    // center magnitude: high-bit share plus low word times the reciprocal
    cq   = (cx[con][32] ? Third2p32 : 32'd0) + {1'b0, mul_p[63:33]};
    // line end: rounded scaled normal added to start, then clamped
    rnd  = {1'b0, mul_p} + 65'd32768;
    rsh  = rnd[64:16];
    ext  = 51'(cur_st[con]);
    eres = mulp_neg ? (ext - $signed({2'b00, rsh})) : (ext + $signed({2'b00, rsh}));
    if (eres > 51'sd2147483647)       esat = 32'sh7fff_ffff;
    else if (eres < -51'sd2147483648) esat = 32'sh8000_0000;
    else                              esat = eres[31:0];
    // divider and root operands
    div_start = (state_q == S_DIVF) && !wait_q;
    rt_start  = (state_q == S_ROOT) && !wait_q;
    div_num   = {1'b0, mag_q[iss][29:0], 17'd0} + {16'd0, len_q};
    div_den   = {1'b0, len_q, 1'b0};
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= 2'd0;
      lvi_q    <= '0;
      cnt_q    <= '0;
      wait_q   <= 1'b0;
      mvalid_q <= 1'b0;
      line_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            for (int c = 0; c < 3; c++) begin
              hpos_q[phase_q][c] <= s_axis_tdata[32*c +: 32];
              hnrm_q[phase_q][c] <= s_axis_tdata[96+32*c +: 32];
            end
            if (phase_q == 2'd2) begin
              phase_q     <= 2'd0;
              last_line_q <= vnorm_q ? 2'd3 : 2'd0;
              state_q     <= S_EDGE;
            end else begin
              phase_q <= phase_q + 2'd1;
            end
          end
        end
        // edge vectors from the held vertices
        S_EDGE: begin
          for (int c = 0; c < 3; c++) begin
            v_q[c] <= 33'(hpos_q[1][c]) - 33'(hpos_q[0][c]);
            w_q[c] <= 33'(hpos_q[2][c]) - 33'(hpos_q[0][c]);
          end
          cnt_q   <= '0;
          state_q <= S_CROSS;
        end
        // six products, two per component
        S_CROSS: begin
          if (cnt_q != 3'd0) begin
            if (!cm1[0]) cr_q[cm1[2:1]] <= term;
            else         cr_q[cm1[2:1]] <= cr_q[cm1[2:1]] - term;
          end
          if (cnt_q == 3'd6) state_q <= S_MAG;
          else               cnt_q <= cnt_q + 3'd1;
        end
        S_MAG: begin
          for (int c = 0; c < 3; c++) begin
            mag_q[c] <= cr_q[c][65] ? 65'(-cr_q[c]) : 65'(cr_q[c]);
            neg_q[c] <= cr_q[c][65];
          end
          state_q <= S_NORM;
        end
        // one-bit shifts until the largest magnitude sits in [2^29, 2^30)
        S_NORM: begin
          cnt_q <= '0;
          if (orv == '0) begin
            for (int c = 0; c < 3; c++) fn_q[c] <= '0;
            state_q <= S_CTR;
          end else if (orv[64:30] != '0) begin
            for (int c = 0; c < 3; c++) mag_q[c] <= {1'b0, mag_q[c][64:1]};
          end else if (!orv[29]) begin
            for (int c = 0; c < 3; c++) mag_q[c] <= {mag_q[c][63:0], 1'b0};
          end else begin
            sum_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_q != 3'd0) sum_q <= sum_q + mul_p;
          if (cnt_q == 3'd3) state_q <= S_ROOT;
          else               cnt_q <= cnt_q + 3'd1;
        end
        S_ROOT: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (rt_done) begin
            wait_q  <= 1'b0;
            len_q   <= rt_root;
            cnt_q   <= '0;
            state_q <= S_DIVF;
          end
        end
        // normal component = round(|c| * 65536 / len)
        S_DIVF: begin
          if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (div_done) begin
            wait_q    <= 1'b0;
            fn_q[iss] <= neg_q[iss] ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
            if (cnt_q == 3'd2) begin
              cnt_q   <= '0;
              state_q <= S_CTR;
            end else begin
              cnt_q <= cnt_q + 3'd1;
            end
          end
        end
        // center component = round(sum / 3), one product per component
        S_CTR: begin
          if (cnt_q != 3'd0) ctr_q[con] <= csum[con][33] ? -$signed(cq) : $signed(cq);
          if (cnt_q == 3'd3) begin
            cnt_q   <= '0;
            line_q  <= '0;
            state_q <= S_LEND;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        // three scaled normal components per line
        S_LEND: begin
          if (cnt_q != 3'd0) begin
            st_q[con]  <= cur_st[con];
            end_q[con] <= esat;
          end
          if (cnt_q == 3'd3) begin
            mvalid_q <= 1'b1;
            fidx_q   <= lvi_q;
            lvi_q    <= lvi_q + 32'd2;
            kind_q   <= (line_q != 2'd0);
            last_q   <= (line_q == last_line_q);
            state_q  <= S_OUT;
          end else begin
            cnt_q <= cnt_q + 3'd1;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            mvalid_q <= 1'b0;
            cnt_q    <= '0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              line_q  <= line_q + 2'd1;
              state_q <= S_LEND;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {fidx_q, end_q[2], end_q[1], end_q[0], st_q[2], st_q[1], st_q[0]};
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule
`default_nettype wire

@@ hdl/nlg_checker.sv @@
// nlg_checker: port-level assertions for the normal line generator
// depends on normal_line_generator_top (bound to it below)
`default_nettype none
module nlg_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [223:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // input side never open while a line waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open during output");

  // stalled line holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped while stalled");

  // last line of a triangle returns the block to accepting vertices
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after last line");

  // an accepted vertex never shows a line in the next cycle
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("line too soon after vertex transfer");

endmodule

bind normal_line_generator_top nlg_checker u_nlg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
